@@ design/fixed_size_pool_allocator_top_assert.svh @@
// assertion macros for the pool allocator checker
// no dependencies; included by the checker file
`ifndef FIXED_SIZE_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define FIXED_SIZE_POOL_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FSPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fspa assertion failed");

// next-cycle implication, disabled in reset
`define FSPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fspa assertion failed");

`endif

@@ design/fspa_pkg.sv @@
// shared types, constants and codes of the pool allocator
// no dependencies
package fspa_pkg;

  // parameter defaults
  localparam int IPB_MAX_DEF    = 64;
  localparam int MAX_BLOCKS_DEF = 16;

  // fixed field widths
  localparam int HANDLE_W   = 10;
  localparam int STATUS_W   = 2;
  localparam int IPB_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IPB  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROW = 1'b1;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_BAD_FREE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_LINK,
    S_IDLE,
    S_GROW,
    S_READ,
    S_POP,
    S_PUSH,
    S_EXH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic link_start;
    logic link_step;
    logic pop_read;
    logic pop_commit;
    logic push_commit;
    logic exh_commit;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic reinit;
    logic head_vld;
    logic grow_ok;
    logic link_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/fixed_size_pool_allocator_top.sv @@
// top level of the fixed-size pool allocator (free list of next-links)
// depends on fspa_pkg, fspa_ctrl, fspa_datapath
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------
//   in      | input     | in_valid_i / in_ready_o   | req_type_i, handle_i
//   out     | output    | out_valid_o / out_ready_i | item_handle_o, status_o
//   cfg     | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// one request at a time; an alloc reads the next link through the registered read
// port of the link memory before its result goes to the output register.
// an alloc that brings in a new block first links it, one link memory write per
// slot, then reads and pops its first item.
// after reset and after each items_per_block write, block 0 is linked with
// in_ready_o low.
// a stalled result holds in the output register; the next request is taken
// meanwhile and waits for the register to free up.
module fixed_size_pool_allocator_top #(
  parameter int ITEMS_PER_BLOCK_MAX = fspa_pkg::IPB_MAX_DEF,
  parameter int MAX_BLOCKS          = fspa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [fspa_pkg::HANDLE_W-1:0]   handle_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fspa_pkg::HANDLE_W-1:0]   item_handle_o,
  output logic [fspa_pkg::STATUS_W-1:0]   status_o,
  input  logic                            cfg_we_i,
  input  logic [fspa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fspa_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fspa_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t sts;

  // controller
  fspa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // datapath
  fspa_datapath #(
    .ITEMS_PER_BLOCK_MAX (ITEMS_PER_BLOCK_MAX),
    .MAX_BLOCKS          (MAX_BLOCKS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .handle_i      (handle_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .item_handle_o (item_handle_o),
    .status_o      (status_o)
  );

endmodule

@@ design/fspa_ctrl.sv @@
// controller state machine of the pool allocator
// depends on fspa_pkg
module fspa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               req_type_i,
  input  fspa_pkg::dp_status_t sts_i,
  output logic               in_ready_o,
  output fspa_pkg::ctl_cmd_t cmd_o
);
  import fspa_pkg::*;

  state_e state_q, state_d;

  // state register, block 0 is linked right after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LINK;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_LINK: begin
        cmd_o.link_step = 1'b1;
        if (sts_i.link_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = !sts_i.reinit;
        if (in_valid_i && !sts_i.reinit) begin
          cmd_o.accept = 1'b1;
          if (req_type_i == REQ_FREE) begin
            state_d = S_PUSH;
          end else if (sts_i.head_vld) begin
            cmd_o.pop_read = 1'b1;
            state_d        = S_POP;
          end else if (sts_i.grow_ok) begin
            cmd_o.link_start = 1'b1;
            state_d          = S_GROW;
          end else begin
            state_d = S_EXH;
          end
        end
      end
      S_GROW: begin
        cmd_o.link_step = 1'b1;
        if (sts_i.link_last) state_d = S_READ;
      end
      S_READ: begin
        cmd_o.pop_read = 1'b1;
        state_d        = S_POP;
      end
      S_POP: begin
        if (sts_i.out_free) begin
          cmd_o.pop_commit = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push_commit = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_EXH: begin
        if (sts_i.out_free) begin
          cmd_o.exh_commit = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_LINK;
    endcase
    // a write to items_per_block relinks block 0
    if (sts_i.reinit) state_d = S_LINK;
  end

endmodule

@@ design/fspa_datapath.sv @@
// datapath of the pool allocator: link memory, free head, block counters, result register
// depends on fspa_pkg
module fspa_datapath #(
  parameter int ITEMS_PER_BLOCK_MAX = fspa_pkg::IPB_MAX_DEF,
  parameter int MAX_BLOCKS          = fspa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fspa_pkg::ctl_cmd_t              cmd_i,
  output fspa_pkg::dp_status_t            sts_o,
  input  logic                            cfg_we_i,
  input  logic [fspa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fspa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [fspa_pkg::HANDLE_W-1:0]   handle_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [fspa_pkg::HANDLE_W-1:0]   item_handle_o,
  output logic [fspa_pkg::STATUS_W-1:0]   status_o
);
  import fspa_pkg::*;

  localparam int POOL_DEPTH = ITEMS_PER_BLOCK_MAX * MAX_BLOCKS;
  localparam int HW         = $clog2(POOL_DEPTH);
  localparam int BW         = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_BASE   = ($clog2(POOL_DEPTH + 1) > HANDLE_W) ?
                              $clog2(POOL_DEPTH + 1) : HANDLE_W;
  localparam int CMP_W      = CMP_BASE + 1;
  localparam int IPB_RST    = (ITEMS_PER_BLOCK_MAX < 64) ? ITEMS_PER_BLOCK_MAX : 64;

  // configuration registers
  logic [IPB_W-1:0] ipb_q;
  logic             grow_q;
  logic [IPB_W-1:0] ipb_wr;

  // pool state
  logic [HW-1:0]    head_q;
  logic             head_vld_q;
  logic [BW-1:0]    blocks_q;
  logic [IPB_W-1:0] cnt_q;
  logic [HW-1:0]    base_q;
  logic [HANDLE_W-1:0] h_q;

  // link memory and its read register
  logic [HW:0]      mem [POOL_DEPTH];
  logic [HW:0]      rd_q;

  // result register
  logic                out_vld_q;
  logic [HANDLE_W-1:0] out_handle_q;
  status_e             out_status_q;

  logic          reinit;
  logic          link_last;
  logic [HW-1:0] link_addr;
  logic          free_hit;
  logic [CMP_W-1:0] h_ext;

  assign reinit    = cfg_we_i && (cfg_idx_i == CFG_IPB);
  assign link_addr = base_q + HW'(cnt_q);
  assign link_last = ({1'b0, cnt_q} + (IPB_W + 1)'(1)) >= {1'b0, ipb_q};

  // saturate the written slot count to 1..max
  always_comb begin
    ipb_wr = cfg_data_i;
    if (cfg_data_i == '0) begin
      ipb_wr = IPB_W'(1);
    end else if (int'(cfg_data_i) > ITEMS_PER_BLOCK_MAX) begin
      ipb_wr = IPB_W'(ITEMS_PER_BLOCK_MAX);
    end
  end

  // a freed handle must fall in the used slots of an active block
  assign h_ext = CMP_W'(h_q);
  always_comb begin
    free_hit = 1'b0;
    for (int b = 0; b < MAX_BLOCKS; b++) begin
      if ((BW'(b) < blocks_q) &&
          (h_ext >= CMP_W'(b * ITEMS_PER_BLOCK_MAX)) &&
          (h_ext < CMP_W'(b * ITEMS_PER_BLOCK_MAX) + CMP_W'(ipb_q))) begin
        free_hit = 1'b1;
      end
    end
  end

  // status toward the controller
  always_comb begin
    sts_o.reinit    = reinit;
    sts_o.head_vld  = head_vld_q;
    sts_o.grow_ok   = grow_q && (blocks_q < BW'(MAX_BLOCKS));
    sts_o.link_last = link_last;
    sts_o.out_free  = !out_vld_q || out_ready_i;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ipb_q  <= IPB_W'(IPB_RST);
      grow_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IPB) ipb_q <= ipb_wr;
      if (cfg_idx_i == CFG_GROW) grow_q <= cfg_data_i[0];
    end
  end

  // free head, block count and linking counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      head_q     <= '0;
      blocks_q   <= BW'(1);
      cnt_q      <= '0;
      base_q     <= '0;
    end else if (reinit) begin
      head_vld_q <= 1'b0;
      blocks_q   <= BW'(1);
      cnt_q      <= '0;
      base_q     <= '0;
    end else begin
      if (cmd_i.link_start) begin
        base_q   <= HW'(int'(blocks_q) * ITEMS_PER_BLOCK_MAX);
        cnt_q    <= '0;
        blocks_q <= blocks_q + BW'(1);
      end
      if (cmd_i.link_step) begin
        cnt_q <= cnt_q + IPB_W'(1);
        if (link_last) begin
          head_q     <= base_q;
          head_vld_q <= 1'b1;
        end
      end
      if (cmd_i.pop_commit) begin
        head_vld_q <= rd_q[HW];
        head_q     <= rd_q[HW-1:0];
      end
      if (cmd_i.push_commit && free_hit) begin
        head_vld_q <= 1'b1;
        head_q     <= HW'(h_q);
      end
    end
  end

  // latched request handle
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) h_q <= handle_i;
  end

  // link memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.link_step) begin
      mem[link_addr] <= {link_last ? 1'b0 : 1'b1, link_addr + HW'(1)};
    end else if (cmd_i.push_commit && free_hit) begin
      mem[HW'(h_q)] <= {head_vld_q, head_q};
    end
    if (cmd_i.pop_read) rd_q <= mem[head_q];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.pop_commit || cmd_i.push_commit || cmd_i.exh_commit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_commit) begin
      out_handle_q <= HANDLE_W'(head_q);
      out_status_q <= STAT_OK;
    end else if (cmd_i.push_commit) begin
      out_handle_q <= h_q;
      out_status_q <= free_hit ? STAT_OK : STAT_BAD_FREE;
    end else if (cmd_i.exh_commit) begin
      out_handle_q <= '0;
      out_status_q <= STAT_EXHAUSTED;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign item_handle_o = out_handle_q;
  assign status_o      = out_status_q;

endmodule

@@ design/fspa_checker.sv @@
// port-level checker of the pool allocator and its bind
// depends on fspa_pkg and fixed_size_pool_allocator_top_assert.svh
`include "fixed_size_pool_allocator_top_assert.svh"

module fspa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [fspa_pkg::HANDLE_W-1:0]   item_handle_o,
  input logic [fspa_pkg::STATUS_W-1:0]   status_o
);
  import fspa_pkg::*;

  // a stalled result holds
  `FSPA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(item_handle_o) && $stable(status_o))

  // only the three defined status codes show up
  `FSPA_ASSERT_IMP(a_status_code, clk_i, rst_ni, out_valid_o,
                   status_o == STAT_OK || status_o == STAT_EXHAUSTED ||
                   status_o == STAT_BAD_FREE)

  // an exhausted pool answers with handle zero
  `FSPA_ASSERT_IMP(a_exh_zero, clk_i, rst_ni, out_valid_o && status_o == STAT_EXHAUSTED,
                   item_handle_o == '0)

  // one request in flight: no accept right after an accept
  `FSPA_ASSERT_NXT(a_one_inflight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind fixed_size_pool_allocator_top fspa_checker u_fspa_checker (.*);
